// ----- hdl/toe_pkg.sv -----
// Shared types and constants for the topological order engine.
// No dependencies.
package toe_pkg;
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLR,
    ST_RCNT,
    ST_SEED,
    ST_POP,
    ST_POPW,
    ST_SCAN,
    ST_EMIT,
    ST_WIPE
  } toe_state_t;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_FINISH = 1'b1;
endpackage

// ----- hdl/topological_order_engine.sv -----
// Top level of the topological order engine (Kahn sort over a constraint memory).
// Depends on toe_pkg.
//
//  channel | ports                                   | role
//  in      | in_valid/in_ready, operation, tasks     | add constraint or finish
//  out     | out_valid/out_ready, task_number, flags | one task of the order per transfer
//  cfg     | cfg_valid/cfg_ready, cfg_task_count     | number of tasks
//
// One add is accepted every cycle while the engine is loading; in_ready is low from a finish until its results are out.
// During a finish the pending counts are cleared over all MAX_TASKS entries, the
// single-port constraint memory read once per cycle sets the length of every scan,
// and each result waits for its registered order read.
// Reset is synchronous, active low; nothing needs clearing in memories after reset.
// out_ready low stalls emission only; the result register holds its transfer.
module topological_order_engine #(
  parameter int MAX_TASKS       = 64,
  parameter int MAX_CONSTRAINTS = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic [6:0] in_first_task,
  input  logic [6:0] in_second_task,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_task_number,
  output logic       out_last,
  output logic       out_no_order,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_task_count
);
  import toe_pkg::*;

  localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CA = (MAX_CONSTRAINTS > 1) ? $clog2(MAX_CONSTRAINTS) : 1;
  localparam int CT = $clog2(MAX_CONSTRAINTS + 1);
  localparam int QW = $clog2(MAX_TASKS + 1);

  // Constraint memory: {first-1, second-1}, six bits each.
  logic [11:0] cmem [MAX_CONSTRAINTS];
  // Pending counts, ready queue and order, each a memory with a registered read.
  logic [CT-1:0] pmem [MAX_TASKS];
  logic [TW-1:0] qmem [MAX_TASKS];
  logic [TW-1:0] omem [MAX_TASKS];

  toe_state_t state_r, state_nxt;
  logic [6:0]    tcnt_r;
  logic [CT-1:0] total_r;
  logic [CT-1:0] k_r, k_nxt;
  logic [6:0]    i_r, i_nxt;
  logic [QW-1:0] head_r, head_nxt, tail_r, tail_nxt, olen_r, olen_nxt;
  logic [TW-1:0] cur_r, cur_nxt;
  logic          rv_r, rv_nxt;     // read of cmem issued last cycle
  logic          pv_r;             // pmem read issued last cycle
  logic [11:0]   crd_r;
  logic [CT-1:0] prd_r;
  logic [TW-1:0] qrd_r, ord_r;
  logic          ov_r, ov_nxt, olast_r, olast_nxt, ono_r, ono_nxt;
  logic [6:0]    otask_r, otask_nxt;

  // memory control
  logic          cwe;
  logic [CA-1:0] caddr;
  logic [11:0]   cwd;
  logic          pwe;
  logic [TW-1:0] pwa, pra;
  logic [CT-1:0] pwd;
  logic          qwe;
  logic [TW-1:0] qwa, qra, owa, ora;
  logic [TW-1:0] qwd;
  logic          owe;
  logic          pre;

  logic [6:0] n;
  assign n = (tcnt_r > 7'(MAX_TASKS)) ? 7'(MAX_TASKS) : tcnt_r;

  logic add_ok;
  assign add_ok = in_first_task != 7'd0 && in_second_task != 7'd0 &&
                  in_first_task <= n && in_second_task <= n &&
                  total_r < CT'(MAX_CONSTRAINTS);

  assign in_ready  = (state_r == ST_LOAD);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_task_number = otask_r;
  assign out_last = olast_r;
  assign out_no_order = ono_r;

  // Fields of the pair read last cycle.
  logic [5:0] ra, rb;
  assign ra = crd_r[11:6];
  assign rb = crd_r[5:0];
  logic pair_in;
  assign pair_in = (7'(ra) < n) && (7'(rb) < n);

  // The read-modify-write of a pending count: an entry is read one cycle, written
  // the next. A write to the same entry in that window is forwarded.
  logic [TW-1:0] pend_a_r;
  logic          fwd_hit;
  logic [CT-1:0] pval;
  logic          fwe_r;
  logic [TW-1:0] fwa_r;
  logic [CT-1:0] fwd_r;
  assign fwd_hit = fwe_r && fwa_r == pend_a_r;
  assign pval = fwd_hit ? fwd_r : prd_r;

  always_comb begin
    state_nxt = state_r;
    k_nxt = k_r; i_nxt = i_r; head_nxt = head_r; tail_nxt = tail_r;
    olen_nxt = olen_r; cur_nxt = cur_r; rv_nxt = 1'b0;
    ov_nxt = ov_r; olast_nxt = olast_r; ono_nxt = ono_r; otask_nxt = otask_r;
    cwe = 1'b0; caddr = k_r[CA-1:0]; cwd = '0;
    pwe = 1'b0; pwa = '0; pwd = '0; pra = '0; pre = 1'b0;
    qwe = 1'b0; qwa = tail_r[TW-1:0]; qwd = '0; qra = head_r[TW-1:0];
    owe = 1'b0; owa = olen_r[TW-1:0]; ora = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (in_operation == OP_FINISH) begin
            state_nxt = ST_CLR; i_nxt = '0;
          end else if (add_ok) begin
            cwe = 1'b1; caddr = total_r[CA-1:0];
            cwd = {6'(in_first_task - 7'd1), 6'(in_second_task - 7'd1)};
          end
        end
      end
      ST_CLR: begin
        pwe = 1'b1; pwa = i_r[TW-1:0]; pwd = '0;
        if (i_r == 7'(MAX_TASKS - 1)) begin
          state_nxt = ST_RCNT; k_nxt = '0;
        end
        i_nxt = i_r + 7'd1;
      end
      ST_RCNT: begin
        // Issue a read of pair k; a pair read last cycle reads its count now,
        // and a count read the cycle before is written back incremented.
        if (k_r < total_r) begin
          caddr = k_r[CA-1:0]; rv_nxt = 1'b1; k_nxt = k_r + CT'(1);
        end
        if (rv_r && pair_in) begin
          pra = ra[TW-1:0]; pre = 1'b1;
        end
        if (pv_r) begin
          pwe = 1'b1; pwa = pend_a_r; pwd = pval + CT'(1);
        end
        if (k_r >= total_r && !rv_r && !pv_r) begin
          state_nxt = ST_SEED; i_nxt = '0; tail_nxt = '0; head_nxt = '0;
          olen_nxt = '0;
        end
      end
      ST_SEED: begin
        // read count i, test it next cycle
        if (i_r < n) begin
          pra = i_r[TW-1:0]; pre = 1'b1; i_nxt = i_r + 7'd1;
        end
        if (pv_r && pval == '0) begin
          qwe = 1'b1; qwd = pend_a_r; tail_nxt = tail_r + QW'(1);
        end
        if (i_r >= n && !pv_r) state_nxt = ST_POP;
      end
      ST_POP: begin
        if (head_r < tail_r) begin
          qra = head_r[TW-1:0]; state_nxt = ST_POPW; head_nxt = head_r + QW'(1);
        end else begin
          state_nxt = ST_EMIT; i_nxt = 7'(olen_r);
        end
      end
      ST_POPW: begin
        cur_nxt = qrd_r;
        owe = 1'b1; owa = olen_r[TW-1:0]; olen_nxt = olen_r + QW'(1);
        state_nxt = ST_SCAN; k_nxt = '0;
      end
      ST_SCAN: begin
        if (k_r < total_r) begin
          caddr = k_r[CA-1:0]; rv_nxt = 1'b1; k_nxt = k_r + CT'(1);
        end
        if (rv_r && pair_in && rb[TW-1:0] == cur_r) begin
          pra = ra[TW-1:0]; pre = 1'b1;
        end
        if (pv_r && pval != '0) begin
          pwe = 1'b1; pwa = pend_a_r; pwd = pval - CT'(1);
          if (pval == CT'(1)) begin
            qwe = 1'b1; qwd = pend_a_r; tail_nxt = tail_r + QW'(1);
          end
        end
        if (k_r >= total_r && !rv_r && !pv_r) state_nxt = ST_POP;
      end
      ST_EMIT: begin
        // i_r counts results left; the order memory read is registered.
        if (olen_r == '0) begin
          if (!ov_r || out_ready) begin
            ov_nxt = 1'b1; otask_nxt = '0; olast_nxt = 1'b1; ono_nxt = 1'b1;
            state_nxt = ST_WIPE;
          end
        end else if (rv_r) begin
          if (!ov_r || out_ready) begin
            ov_nxt = 1'b1; otask_nxt = 7'(ord_r) + 7'd1; ono_nxt = 1'b0;
            olast_nxt = (i_r == 7'd1); i_nxt = i_r - 7'd1;
            if (i_r == 7'd1) state_nxt = ST_WIPE;
          end else rv_nxt = 1'b1;
        end else begin
          ora = TW'(i_r - 7'd1); rv_nxt = 1'b1;
        end
      end
      ST_WIPE: begin
        if (!ov_r || out_ready) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // In emit, the read address must hold while a result waits.
  logic [TW-1:0] ora_r;

  always_ff @(posedge clk) begin
    if (cwe) cmem[caddr] <= cwd;
    crd_r <= cmem[caddr];
    if (pwe) pmem[pwa] <= pwd;
    prd_r <= pmem[pra];
    if (qwe) qmem[qwa] <= qwd;
    qrd_r <= qmem[qra];
    if (owe) omem[owa] <= cur_nxt;
    ord_r <= omem[(state_r == ST_EMIT && rv_r) ? ora_r : ora];
    if (!(state_r == ST_EMIT && rv_r)) ora_r <= ora;
    pend_a_r <= (state_r == ST_SEED) ? pra : pra;
    fwa_r <= pwa; fwd_r <= pwd;
    otask_r <= otask_nxt; olast_r <= olast_nxt; ono_r <= ono_nxt;
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD; tcnt_r <= 7'd64; total_r <= '0;
      k_r <= '0; i_r <= '0; head_r <= '0; tail_r <= '0; olen_r <= '0;
      rv_r <= 1'b0; pv_r <= 1'b0; ov_r <= 1'b0; fwe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) tcnt_r <= cfg_task_count;
      if (state_r == ST_LOAD && in_valid && in_operation == OP_ADD && add_ok)
        total_r <= total_r + CT'(1);
      else if (state_r == ST_WIPE && state_nxt == ST_LOAD)
        total_r <= '0;
      k_r <= k_nxt; i_r <= i_nxt; head_r <= head_nxt; tail_r <= tail_nxt;
      olen_r <= olen_nxt; rv_r <= rv_nxt; pv_r <= pre; ov_r <= ov_nxt;
      fwe_r <= pwe;
    end
  end
endmodule

// ----- hdl/toe_checker.sv -----
// Port-level checker for the topological order engine, bound to the top level.
// Depends on topological_order_engine ports only.
module toe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_task_number,
  input logic       out_last,
  input logic       out_no_order
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_task_number))
    else $error("result changed while stalled");
  a_noord: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_order |-> out_last && out_task_number == 7'd0)
    else $error("no_order result malformed");
  a_task: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_no_order |-> out_task_number != 7'd0)
    else $error("task number zero");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("accepting input while emitting");
endmodule

bind topological_order_engine toe_checker u_toe_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_task_number(out_task_number),
  .out_last(out_last), .out_no_order(out_no_order)
);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for topological_order_engine: a directed part, then random
// problem sets under several handshake idling phases. Depends on toe_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import toe_pkg::*;

  localparam int NumTasks     = 64;
  localparam int NumPairs     = 1024;
  localparam int SettleCycles = 2000;
  localparam int CycleLimit   = 1500000;

  typedef struct {
    logic       op;
    logic [6:0] first_task;
    logic [6:0] second_task;
  } request_t;

  typedef struct {
    logic [6:0] task_no;
    logic       last;
    logic       no_order;
  } order_entry_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_operation;
  logic [6:0] in_first_task;
  logic [6:0] in_second_task;
  logic       out_valid;
  logic       out_ready;
  logic [6:0] out_task_number;
  logic       out_last;
  logic       out_no_order;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [6:0] cfg_task_count;

  topological_order_engine DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_first_task  (in_first_task),
    .in_second_task (in_second_task),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_task_number(out_task_number),
    .out_last       (out_last),
    .out_no_order   (out_no_order),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_task_count (cfg_task_count)
  );

  // Requests waiting to be driven, and the order entries the sort should still emit.
  request_t     request_q[$];
  order_entry_t order_q[$];

  // The sorter's own state as the testbench tracks it.
  logic [6:0] task_count_shadow;
  logic [5:0] pair_first[NumPairs];
  logic [5:0] pair_second[NumPairs];
  int         pair_total;

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Applies one accepted request to the tracked state. An add records a constraint;
  // a finish runs Kahn's algorithm over the stored pairs and queues the reversed order.
  function automatic void apply_request(request_t req);
    int n, k, i, t, head, tail, olen;
    int a, b;
    int pending[NumTasks];
    int fifo[NumTasks];
    int seq[NumTasks];
    order_entry_t e;
    n = (task_count_shadow > NumTasks) ? NumTasks : task_count_shadow;
    if (req.op == OP_ADD) begin
      a = req.first_task;
      b = req.second_task;
      // Tasks out of range and adds to a full store are dropped.
      if (a == 0 || b == 0 || a > n || b > n) return;
      if (pair_total >= NumPairs) return;
      pair_first[pair_total]  = 6'(a - 1);
      pair_second[pair_total] = 6'(b - 1);
      pair_total++;
      return;
    end
    // Pending counts are rebuilt here, so a task count lowered after the adds
    // simply hides the pairs that name the removed tasks.
    for (i = 0; i < NumTasks; i++) pending[i] = 0;
    for (k = 0; k < pair_total; k++)
      if (pair_first[k] < n && pair_second[k] < n) pending[pair_first[k]]++;
    head = 0;
    tail = 0;
    olen = 0;
    for (i = 0; i < n; i++)
      if (pending[i] == 0) begin
        fifo[tail] = i;
        tail++;
      end
    while (head < tail) begin
      t = fifo[head];
      head++;
      seq[olen] = t;
      olen++;
      for (k = 0; k < pair_total; k++) begin
        if (pair_second[k] != t || pair_first[k] >= n) continue;
        a = pair_first[k];
        if (pending[a] > 0) begin
          pending[a]--;
          if (pending[a] == 0 && tail < NumTasks) begin
            fifo[tail] = a;
            tail++;
          end
        end
      end
    end
    if (olen == 0) begin
      // Nothing could be ordered: a single flagged entry.
      e.task_no  = 7'd0;
      e.last     = 1'b1;
      e.no_order = 1'b1;
      order_q = {order_q, e};
    end else begin
      for (i = olen; i > 0; i--) begin
        e.task_no  = 7'(seq[i - 1] + 1);
        e.last     = (i == 1);
        e.no_order = 1'b0;
        order_q = {order_q, e};
      end
    end
    pair_total = 0;
  endfunction

  // Driver: a new request is presented whenever the previous one has transferred
  // or the channel is empty, unless the sender chooses to idle this cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_operation   <= OP_ADD;
      in_first_task  <= 7'd0;
      in_second_task <= 7'd0;
    end else begin
      if (in_valid && in_ready)
        apply_request('{in_operation, in_first_task, in_second_task});
      if (!in_valid || in_ready) begin
        if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid       <= 1'b1;
          in_operation   <= request_q[0].op;
          in_first_task  <= request_q[0].first_task;
          in_second_task <= request_q[0].second_task;
          void'(request_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result transfer is checked against the oldest queued entry.
  always @(posedge clk) begin
    order_entry_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (order_q.size() == 0) begin
          $error("unexpected result: task_number %0d last %0b no_order %0b",
                 out_task_number, out_last, out_no_order);
          mismatches++;
        end else begin
          e = order_q.pop_front();
          if (out_task_number !== e.task_no) begin
            $error("task_number: expected %0d, got %0d", e.task_no, out_task_number);
            mismatches++;
          end
          if (out_last !== e.last) begin
            $error("last: expected %0b, got %0b", e.last, out_last);
            mismatches++;
          end
          if (out_no_order !== e.no_order) begin
            $error("no_order: expected %0b, got %0b", e.no_order, out_no_order);
            mismatches++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_request(logic op, int a, int b);
    request_t r;
    r.op          = op;
    r.first_task  = 7'(a);
    r.second_task = 7'(b);
    request_q = {request_q, r};
  endtask

  // Holds the sender until every request has transferred and every entry has
  // arrived, then lets the engine finish its clearing work.
  task automatic drain();
    do @(negedge clk);
    while (request_q.size() > 0 || in_valid || order_q.size() > 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // The task count is only written while the engine is idle.
  task automatic write_task_count(int value);
    @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_task_count <= 7'(value);
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    task_count_shadow = 7'(value);
    cfg_valid <= 1'b0;
  endtask

  // One well-formed problem of random content: mostly acyclic constraints, some
  // possibly cyclic, some with tasks out of range, then a finish.
  task automatic push_problem(int n, ref int issued);
    int adds, j, r, x, y;
    adds = $urandom_range(0, 12);
    for (j = 0; j < adds; j++) begin
      r = $urandom_range(99);
      x = $urandom_range(1, n);
      y = $urandom_range(1, n);
      if (r < 8)
        push_request(OP_ADD, $urandom_range(0, 127), $urandom_range(0, 127));
      else if (r < 18)
        push_request(OP_ADD, x, y);
      else
        push_request(OP_ADD, (x > y) ? x : y, (x > y) ? y : x);
    end
    push_request(OP_FINISH, $urandom_range(0, 127), $urandom_range(0, 127));
    issued += adds + 1;
  endtask

  initial begin
    int phase, issued, n;
    int idle_pct[4];
    int stall_pct[4];
    idle_pct  = '{0, 70, 0, 13};
    stall_pct = '{0, 0, 70, 13};
    mismatches        = 0;
    cycles            = 0;
    pair_total        = 0;
    task_count_shadow = 7'd64;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_task_count    = 7'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset task count, bit 6 of both task fields, task zero and tasks
    // above the count dropped, a self loop left out of the order.
    push_request(OP_ADD, 1, 2);
    push_request(OP_ADD, 2, 3);
    push_request(OP_ADD, 64, 1);
    push_request(OP_ADD, 0, 5);
    push_request(OP_ADD, 127, 127);
    push_request(OP_ADD, 5, 5);
    push_request(OP_FINISH, 0, 0);
    // A finish with no constraints emits all 64 tasks.
    push_request(OP_FINISH, 127, 127);
    drain();

    // A two-task cycle leaves nothing orderable.
    write_task_count(2);
    push_request(OP_ADD, 1, 2);
    push_request(OP_ADD, 2, 1);
    push_request(OP_FINISH, 0, 0);
    drain();

    // Lowering the task count between the adds and the finish.
    write_task_count(10);
    push_request(OP_ADD, 9, 10);
    push_request(OP_ADD, 10, 1);
    push_request(OP_ADD, 1, 2);
    push_request(OP_ADD, 11, 1);
    drain();
    write_task_count(5);
    push_request(OP_FINISH, 1, 1);
    drain();

    // A single task.
    write_task_count(1);
    push_request(OP_FINISH, 0, 0);
    push_request(OP_ADD, 1, 1);
    push_request(OP_FINISH, 0, 0);
    drain();

    // Random problems, one idling phase per task count, extremes included.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       n = 64;
        1:       n = $urandom_range(2, 12);
        2:       n = 1;
        default: n = $urandom_range(2, 16);
      endcase
      write_task_count(n);
      send_idle_pct  = idle_pct[phase];
      recv_stall_pct = stall_pct[phase];
      issued = 0;
      while (issued < 34) push_problem(n, issued);
      drain();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
